// ===== rtl/ins_sort_pkg.sv =====
// Shared types and defaults for the insertion sorter.
// No dependencies; used by ins_sort_cell and insertion_sorter.
package ins_sort_pkg;

  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Sorter phase: collect values, then emit the sorted run
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  // Per-cycle command broadcast to every cell in the chain
  typedef struct packed {
    logic insert;   // a new value is written into the chain
    logic shift;    // the chain moves one place toward cell 0
  } cell_ctrl_t;

endpackage

// ===== rtl/ins_sort_cell.sv =====
// One cell of the sorting chain: holds a single value and its valid bit.
// Depends on ins_sort_pkg for the cell control struct.
module ins_sort_cell #(
  parameter int unsigned VALUE_WIDTH = ins_sort_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ins_sort_pkg::cell_ctrl_t      ctrl,
  input  logic signed [VALUE_WIDTH-1:0] new_val,
  input  logic                          left_gt,
  input  logic signed [VALUE_WIDTH-1:0] left_val,
  input  logic                          left_vld,
  input  logic signed [VALUE_WIDTH-1:0] right_val,
  input  logic                          right_vld,
  output logic signed [VALUE_WIDTH-1:0] val,
  output logic                          vld,
  output logic                          gt
);
  import ins_sort_pkg::*;

  logic signed [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                          vld_r, vld_nxt;

  // An empty cell counts as greater than any value
  assign gt = !vld_r || (val_r > new_val);

  // Shift toward the head when draining; on insert take the left
  // neighbor's entry, or the new value if this is the insertion point
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctrl.shift) begin
      val_nxt = right_val;
      vld_nxt = right_vld;
    end else if (ctrl.insert && gt) begin
      if (left_gt) begin
        val_nxt = left_val;
        vld_nxt = left_vld;
      end else begin
        val_nxt = new_val;
        vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

// ===== rtl/insertion_sorter.sv =====
// Top level of the streaming insertion sorter: a chain of DEPTH cells.
// Depends on ins_sort_pkg and ins_sort_cell.
//
// Values are taken one per cycle and placed into a chain of DEPTH cells in
// the same cycle: every cell compares the new value against its own entry,
// and the cells at and beyond the insertion point move one place down.
// Equal values keep their arrival order. A value that arrives when all
// cells are full is dropped and every result of that set carries
// out_overflow. On a request with in_last the value is inserted and the
// chain then drains from cell 0, one result per cycle unless out_stall
// holds it, in ascending order, with out_last on the final one. During the
// drain in_stall is high, so the block takes no value of the next set until
// the final result of this one has been taken.
module insertion_sorter #(
  parameter int unsigned DEPTH       = ins_sort_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = ins_sort_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic                          out_last,
  output logic                          out_overflow
);
  import ins_sort_pkg::*;

  state_t     state_r, state_nxt;
  logic       dropped_r, dropped_nxt;
  cell_ctrl_t ctrl;
  logic       in_acc, out_acc, full;

  logic signed [VALUE_WIDTH-1:0] cell_val [DEPTH];
  logic        [DEPTH-1:0]       cell_vld;
  logic        [DEPTH-1:0]       cell_gt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign full    = cell_vld[DEPTH-1];

  // Drop the value when the chain is full
  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  // Build the chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                          l_gt, l_vld, r_vld;
    logic signed [VALUE_WIDTH-1:0] l_val, r_val;

    if (i == 0) begin : g_head
      assign l_gt  = 1'b0;
      assign l_vld = 1'b0;
      assign l_val = '0;
    end else begin : g_body
      assign l_gt  = cell_gt[i-1];
      assign l_vld = cell_vld[i-1];
      assign l_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_vld = 1'b0;
      assign r_val = '0;
    end else begin : g_inner
      assign r_vld = cell_vld[i+1];
      assign r_val = cell_val[i+1];
    end

    ins_sort_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_val   (in_value),
      .left_gt   (l_gt),
      .left_val  (l_val),
      .left_vld  (l_vld),
      .right_val (r_val),
      .right_vld (r_vld),
      .val       (cell_val[i]),
      .vld       (cell_vld[i]),
      .gt        (cell_gt[i])
    );
  end

  // Next state: drain after the last request, refill after the last result
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_acc && in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc && out_last) begin
          state_nxt = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // Overflow mark: set on a dropped value, clear once the run is out
  always_comb begin
    dropped_nxt = dropped_r;
    if (in_acc && full) begin
      dropped_nxt = 1'b1;
    end else if (out_acc && out_last) begin
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_FILL;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Outputs: the head cell drives the result channel
  always_comb begin
    in_stall  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_FILL:  in_stall = 1'b0;
      ST_DRAIN: begin
        in_stall  = 1'b1;
        out_valid = cell_vld[0];
      end
      default: in_stall = 1'b0;
    endcase
  end

  assign out_value    = cell_val[0];
  assign out_last     = cell_vld[0] && !cell_vld[1];
  assign out_overflow = dropped_r;

`ifndef SYNTHESIS
  // A last request always starts a run on the next cycle
  a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> out_valid)
    else $error("no result after last request");

  // The chain is empty once the final result is taken
  a_empty_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_last |=> !out_valid && !cell_vld[0])
    else $error("chain not empty after final result");

  // Occupied cells form a contiguous run from the head
  a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_vld[DEPTH-1:1] & ~cell_vld[DEPTH-2:0]) == '0)
    else $error("gap in chain occupancy");

  // A request on a full chain marks the set as overflowed
  a_drop_marks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && full |=> dropped_r)
    else $error("dropped value not flagged");
`endif

endmodule

// ===== sim/insertion_sorter_checker.sv =====
// Scoreboard for the insertion sorter: watches the request and result channels,
// predicts each sorted run and compares it field by field.
// Depends on ins_sort_pkg for the default sizes.
module insertion_sorter_checker #(
  parameter int unsigned DEPTH       = ins_sort_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = ins_sort_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          in_last,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [VALUE_WIDTH-1:0] out_value,
  input  logic                          out_last,
  input  logic                          out_overflow,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;
    logic                          overflow;
  } sorted_result_t;

  // Shadow copy of the sorter's store
  logic signed [VALUE_WIDTH-1:0] held_values [DEPTH];
  int unsigned                   held_count;
  logic                          held_dropped;

  sorted_result_t sorted_run_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Place a value after every held value not greater than it, or drop it
  function automatic void place_value(logic signed [VALUE_WIDTH-1:0] v);
    int i;
    if (held_count >= DEPTH) begin
      held_dropped = 1'b1;
      return;
    end
    for (i = held_count; i > 0 && held_values[i-1] > v; i--)
      held_values[i] = held_values[i-1];
    held_values[i] = v;
    held_count++;
  endfunction

  // Queue the whole store in ascending order, then empty it
  function automatic void release_run();
    sorted_result_t r;
    for (int i = 0; i < held_count; i++) begin
      r.value    = held_values[i];
      r.last     = (i + 1 == held_count);
      r.overflow = held_dropped;
      sorted_run_q.push_back(r);
    end
    held_count   = 0;
    held_dropped = 1'b0;
  endfunction

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= 10)
      $display("%t: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    sorted_result_t want;
    if (!rst_n) begin
      held_count   = 0;
      held_dropped = 1'b0;
      sorted_run_q.delete();
    end else begin
      // Compare a result against the oldest prediction
      if (out_valid && !out_stall) begin
        if (sorted_run_q.size() == 0) begin
          note_failure($sformatf("unexpected result: value %0d last %0b overflow %0b",
                                 out_value, out_last, out_overflow));
        end else begin
          want = sorted_run_q.pop_front();
          if (want.value !== out_value || want.last !== out_last ||
              want.overflow !== out_overflow)
            note_failure($sformatf(
              "mismatch: expected value %0d last %0b overflow %0b, got %0d %0b %0b",
              want.value, want.last, want.overflow, out_value, out_last, out_overflow));
        end
      end
      // Track an accepted request in the shadow store
      if (in_valid && !in_stall) begin
        place_value(in_value);
        if (in_last)
          release_run();
      end
    end
    pending = sorted_run_q.size();
  end

endmodule

// ===== sim/insertion_sorter_tb.sv =====
// Testbench top for the insertion sorter: clock, reset, request stimulus,
// result stalls and the final verdict. Depends on ins_sort_pkg, insertion_sorter
// and insertion_sorter_checker.
module insertion_sorter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = ins_sort_pkg::DEPTH_DEF;
  localparam int unsigned VW          = ins_sort_pkg::VALUE_WIDTH_DEF;
  localparam int          IDLE_LIMIT  = 4000;
  localparam int          DRAIN_TAIL  = 2 * DEPTH + 8;

  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic signed [VW-1:0] in_value  = '0;
  logic                 in_last   = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [VW-1:0] out_value;
  logic                 out_last;
  logic                 out_overflow;

  int fail_count;
  int pending;
  int tx_idle_pct = 14;
  int rx_idle_pct = 47;
  int idle_cycles = 0;
  int requests_sent = 0;

  insertion_sorter #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VW)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

  insertion_sorter_checker #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VW)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_overflow (out_overflow),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("insertion_sorter_tb NOT OK");
        $finish;
      end
    end
  end

  // Present one request after a random gap and hold it until accepted
  task automatic send_request(input logic signed [VW-1:0] v, input logic l);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= l;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    requests_sent++;
  endtask

  // Mix of extremes, a narrow band around zero for ties, and full-range noise
  function automatic logic signed [VW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3, 4: return $signed(VW'($urandom_range(0, 12))) - 6;
      default: return VW'($urandom);
    endcase
  endfunction

  // Sizes: mostly partial sets, some exactly full, a few overflowing
  task automatic send_random_set();
    int n;
    case ($urandom_range(0, 7))
      0:       n = DEPTH;
      1:       n = $urandom_range(DEPTH + 1, DEPTH + 4);
      default: n = $urandom_range(1, DEPTH - 1);
    endcase
    for (int k = 0; k < n; k++)
      send_request(pick_value(), k == n - 1);
  endtask

  initial begin
    logic signed [VW-1:0] mixed_set [7];
    int phase_end [3];
    mixed_set = '{VAL_MAX, VAL_MIN, 0, -1, 1, 5, 5};
    phase_end = '{130, 260, 395};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes, zero, both signs and a tie in one set
    foreach (mixed_set[k])
      send_request(mixed_set[k], k == 6);
    // Set of a single value
    send_request(-5, 1'b1);
    // Fill the store in descending order, then drop the last value
    for (int k = DEPTH; k >= 1; k--)
      send_request(k, 1'b0);
    send_request(VAL_MIN, 1'b1);

    // Random sets under three idle patterns
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle_pct = 14;
          rx_idle_pct = 47;
        end
        1: begin
          tx_idle_pct = 47;
          rx_idle_pct = 14;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (requests_sent < 25 + phase_end[p])
        send_random_set();
    end
    in_valid <= 1'b0;

    // Drain the last sorted run, then settle
    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    // No failure may be logged and every predicted result must have arrived
    if (fail_count == 0 && pending == 0)
      $display("insertion_sorter_tb OK");
    else
      $display("insertion_sorter_tb NOT OK");
    $finish;
  end

endmodule
